// ----- rtl/mfg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mfg_pkg;

   localparam int MAX_WIDTH_DEF     = 1024;
   localparam int WINDOW_RADIUS_DEF = 3;

   localparam int PIX_W  = 8;
   localparam int FW_W   = 11;
   localparam int FH_W   = 13;
   localparam int OY_W   = 12;
   localparam int PROD_W = 24;
   localparam int SUM_W  = 25;

   localparam int HEIGHT_LIMIT = 4096;
   localparam int FW_RESET     = 640;
   localparam int FH_RESET     = 480;

   localparam int WEIGHT_R = 13763;
   localparam int WEIGHT_G = 46531;
   localparam int WEIGHT_B = 4588;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic write;
      logic emit;
      logic frame_end;
      logic interior;
   } ctrl_type;

   typedef struct packed {
      logic             valid;
      logic             frame_end;
      logic             interior;
      logic [PIX_W-1:0] gray;
   } meta_type;

endpackage
`default_nettype wire

// ----- rtl/median_filter_7x7_gray_core.sv -----
// channel   direction  handshake                word
// req_      in         req_valid / req_stall    action, red, green, blue
// rsp_      out        rsp_valid / rsp_stall    gray_out, frame_end
// csr_      in         csr_valid / csr_ready    index, wdata (width, height)
//
// one word per cycle unless rsp_stall holds a result; each word passes through:
// input stage (products, line store read) at the accepting edge, window, one rank cell
// per bit, output register.
// six line store rams, one per slot; each word taken reads all, a pixel writes one.
// synchronous active-high reset clears counters, valid bits and sizes to 640x480.
// a held result under rsp_stall stalls the whole chain and raises req_stall.
`timescale 1ns / 1ps
`default_nettype none
module median_filter_7x7_gray_core #(
   parameter int MAX_WIDTH     = mfg_pkg::MAX_WIDTH_DEF,
   parameter int WINDOW_RADIUS = mfg_pkg::WINDOW_RADIUS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_action,
   input  wire logic [mfg_pkg::PIX_W-1:0]        req_red,
   input  wire logic [mfg_pkg::PIX_W-1:0]        req_green,
   input  wire logic [mfg_pkg::PIX_W-1:0]        req_blue,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [mfg_pkg::PIX_W-1:0]        rsp_gray_out,
   output logic                                  rsp_frame_end,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [mfg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mfg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mfg_pkg::*;

   localparam int SIDE  = 2*WINDOW_RADIUS + 1;
   localparam int AREA  = SIDE*SIDE;
   localparam int LINES = 2*WINDOW_RADIUS;
   localparam int RANK  = AREA/2;
   localparam int KW    = $clog2(AREA+1);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH+1);
   localparam int RSW   = $clog2(LINES);

   // sizes and counters
   logic [FW_W-1:0]  width_ff, width_in;
   logic [FH_W-1:0]  height_ff, height_in;
   logic [XW-1:0]    col_ff, col_in;
   logic [FH_W-1:0]  row_ff, row_in;
   logic [RSW-1:0]   rs_ff, rs_in;
   logic [XW-1:0]    ox_ff, ox_in;
   logic [OY_W-1:0]  oy_ff, oy_in;
   logic             done_ff, done_in;

   logic [FH_W-1:0]  w_ext, h_use;
   logic [WW-1:0]    w_use;
   logic             adv, acc, step, pix, emit, fend, interior, col_last, ox_last;

   always_comb begin
      w_ext = FH_W'(width_ff);
      if (w_ext < FH_W'(SIDE)) begin
         w_ext = FH_W'(SIDE);
      end else if (w_ext > FH_W'(MAX_WIDTH)) begin
         w_ext = FH_W'(MAX_WIDTH);
      end
      h_use = height_ff;
      if (h_use < FH_W'(SIDE)) begin
         h_use = FH_W'(SIDE);
      end else if (h_use > FH_W'(HEIGHT_LIMIT)) begin
         h_use = FH_W'(HEIGHT_LIMIT);
      end
   end
   assign w_use = w_ext[WW-1:0];

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;
   assign acc       = req_valid && adv;
   assign step      = acc && (done_ff || !req_action);
   assign pix       = acc && !done_ff && !req_action;
   assign col_last  = WW'(col_ff) == w_use - WW'(1);
   assign ox_last   = WW'(ox_ff) == w_use - WW'(1);
   assign emit      = step && (row_ff > FH_W'(WINDOW_RADIUS) ||
                      (row_ff == FH_W'(WINDOW_RADIUS) && col_ff >= XW'(WINDOW_RADIUS)));
   assign fend      = emit && ox_last && FH_W'(oy_ff) == h_use - FH_W'(1);
   assign interior  = ox_ff >= XW'(WINDOW_RADIUS) &&
                      WW'(ox_ff) < w_use - WW'(WINDOW_RADIUS) &&
                      oy_ff >= OY_W'(WINDOW_RADIUS) &&
                      FH_W'(oy_ff) < h_use - FH_W'(WINDOW_RADIUS);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      rs_in     = rs_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      done_in   = done_ff;
      if (step) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_ff + FH_W'(1);
            rs_in  = (rs_ff == RSW'(LINES-1)) ? '0 : rs_ff + RSW'(1);
            if (pix && row_ff == h_use - FH_W'(1)) begin
               done_in = 1'b1;
            end
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
      if (emit) begin
         if (ox_last) begin
            ox_in = '0;
            oy_in = oy_ff + OY_W'(1);
         end else begin
            ox_in = ox_ff + XW'(1);
         end
      end
      if (fend) begin
         col_in  = '0;
         row_in  = '0;
         rs_in   = '0;
         ox_in   = '0;
         oy_in   = '0;
         done_in = 1'b0;
      end
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_in = csr_wdata[FW_W-1:0];
               col_in   = '0;
               row_in   = '0;
               rs_in    = '0;
               ox_in    = '0;
               oy_in    = '0;
               done_in  = 1'b0;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = csr_wdata[FH_W-1:0];
               col_in    = '0;
               row_in    = '0;
               rs_in     = '0;
               ox_in     = '0;
               oy_in     = '0;
               done_in   = 1'b0;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FW_W'(FW_RESET);
         height_ff <= FH_W'(FH_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
         rs_ff     <= '0;
         ox_ff     <= '0;
         oy_ff     <= '0;
         done_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         rs_ff     <= rs_in;
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
         done_ff   <= done_in;
      end
   end

   // first stage: products, position, control
   ctrl_type          s1_ctrl_ff;
   logic [XW-1:0]     s1_x_ff;
   logic [RSW-1:0]    s1_rs_ff;
   logic [PROD_W-1:0] pr_ff, pg_ff, pb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ctrl_ff.valid <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctrl_ff.write     <= pix;
         s1_ctrl_ff.emit      <= emit;
         s1_ctrl_ff.frame_end <= fend;
         s1_ctrl_ff.interior  <= interior;
         s1_x_ff              <= col_ff;
         s1_rs_ff             <= rs_ff;
         pr_ff <= PROD_W'(WEIGHT_R) * PROD_W'(req_red);
         pg_ff <= PROD_W'(WEIGHT_G) * PROD_W'(req_green);
         pb_ff <= PROD_W'(WEIGHT_B) * PROD_W'(req_blue);
      end
   end

   logic [SUM_W-1:0] gsum;
   logic [PIX_W-1:0] gray;

   assign gsum = SUM_W'(pr_ff) + SUM_W'(pg_ff) + SUM_W'(pb_ff);
   assign gray = (gsum[SUM_W-1:16] > (SUM_W-16)'(255)) ? PIX_W'(255) : gsum[PIX_W+15:16];

   // line store
   logic [PIX_W-1:0] ram_rd [LINES];

   for (genvar j = 0; j < LINES; j++) begin : g_line
      mfg_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (s1_ctrl_ff.valid && s1_ctrl_ff.write && s1_rs_ff == RSW'(j)),
         .wr_addr (s1_x_ff),
         .wr_data (gray),
         .rd_en   (acc),
         .rd_addr (col_ff),
         .rd_data (ram_rd[j])
      );
   end

   logic [SIDE*PIX_W-1:0] col_vec;
   logic [RSW:0]          slot_sum;
   logic [RSW-1:0]        slot;

   always_comb begin
      slot_sum = '0;
      slot     = '0;
      for (int k = 0; k < LINES; k++) begin
         slot_sum = (RSW+1)'(s1_rs_ff) + (RSW+1)'(k);
         if (slot_sum >= (RSW+1)'(LINES)) begin
            slot_sum = slot_sum - (RSW+1)'(LINES);
         end
         slot = slot_sum[RSW-1:0];
         col_vec[k*PIX_W +: PIX_W] = ram_rd[slot];
      end
      col_vec[LINES*PIX_W +: PIX_W] = gray;
   end

   // window
   logic [AREA*PIX_W-1:0] win;
   meta_type              s2_meta_ff;

   mfg_window #(
      .SIDE (SIDE)
   ) u_window (
      .clock   (clock),
      .en      (adv && s1_ctrl_ff.valid),
      .col_in  (col_vec),
      .win_out (win)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_meta_ff.valid <= 1'b0;
      end else if (adv) begin
         s2_meta_ff.valid <= s1_ctrl_ff.valid && s1_ctrl_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_meta_ff.frame_end <= s1_ctrl_ff.frame_end;
         s2_meta_ff.interior  <= s1_ctrl_ff.interior;
         s2_meta_ff.gray      <= '0;
      end
   end

   // rank chain, one cell per bit, msb first
   logic [AREA*PIX_W-1:0] vals_c [PIX_W+1];
   logic [AREA-1:0]       mask_c [PIX_W+1];
   logic [KW-1:0]         rank_c [PIX_W+1];
   logic [PIX_W-1:0]      acc_c  [PIX_W+1];
   meta_type              meta_c [PIX_W+1];

   always_comb begin
      vals_c[0]           = win;
      mask_c[0]           = '1;
      rank_c[0]           = KW'(RANK);
      acc_c[0]            = '0;
      meta_c[0]           = s2_meta_ff;
      meta_c[0].gray      = win[(WINDOW_RADIUS*SIDE+WINDOW_RADIUS)*PIX_W +: PIX_W];
   end

   for (genvar b = 0; b < PIX_W; b++) begin : g_cell
      mfg_rank_cell #(
         .AREA (AREA),
         .BIT  (PIX_W-1-b)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .vals_in  (vals_c[b]),
         .mask_in  (mask_c[b]),
         .rank_in  (rank_c[b]),
         .acc_in   (acc_c[b]),
         .meta_in  (meta_c[b]),
         .vals_out (vals_c[b+1]),
         .mask_out (mask_c[b+1]),
         .rank_out (rank_c[b+1]),
         .acc_out  (acc_c[b+1]),
         .meta_out (meta_c[b+1])
      );
   end

   // output word
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_gray_ff;
   logic             rsp_fend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= meta_c[PIX_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_gray_ff <= meta_c[PIX_W].interior ? acc_c[PIX_W] : meta_c[PIX_W].gray;
         rsp_fend_ff <= meta_c[PIX_W].frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_gray_out  = rsp_gray_ff;
   assign rsp_frame_end = rsp_fend_ff;

endmodule
`default_nettype wire

// ----- rtl/mfg_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/mfg_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfg_window #(
   parameter int SIDE = 7
) (
   input  wire logic                                  clock,
   input  wire logic                                  en,
   input  wire logic [SIDE*mfg_pkg::PIX_W-1:0]        col_in,
   output logic      [SIDE*SIDE*mfg_pkg::PIX_W-1:0]   win_out
);
   import mfg_pkg::*;

   logic [SIDE*SIDE*PIX_W-1:0] win_ff;
   logic [SIDE*SIDE*PIX_W-1:0] win_in;

   always_comb begin
      win_in = win_ff;
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE - 1; c++) begin
            win_in[(r*SIDE+c)*PIX_W +: PIX_W] = win_ff[(r*SIDE+c+1)*PIX_W +: PIX_W];
         end
         win_in[(r*SIDE+SIDE-1)*PIX_W +: PIX_W] = col_in[r*PIX_W +: PIX_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         win_ff <= win_in;
      end
   end

   assign win_out = win_ff;

endmodule
`default_nettype wire

// ----- rtl/mfg_rank_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfg_rank_cell #(
   parameter int AREA = 49,
   parameter int BIT  = 7
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic [AREA*mfg_pkg::PIX_W-1:0]    vals_in,
   input  wire logic [AREA-1:0]                   mask_in,
   input  wire logic [$clog2(AREA+1)-1:0]         rank_in,
   input  wire logic [mfg_pkg::PIX_W-1:0]         acc_in,
   input  wire mfg_pkg::meta_type                 meta_in,
   output logic      [AREA*mfg_pkg::PIX_W-1:0]    vals_out,
   output logic      [AREA-1:0]                   mask_out,
   output logic      [$clog2(AREA+1)-1:0]         rank_out,
   output logic      [mfg_pkg::PIX_W-1:0]         acc_out,
   output mfg_pkg::meta_type                      meta_out
);
   import mfg_pkg::*;

   localparam int KW = $clog2(AREA+1);

   logic [AREA*PIX_W-1:0] vals_ff;
   logic [AREA-1:0]       mask_ff, mask_in_nx;
   logic [KW-1:0]         rank_ff, rank_nx;
   logic [PIX_W-1:0]      acc_ff, acc_nx;
   meta_type              meta_ff;
   logic [AREA-1:0]       zeros, ones;
   logic [KW-1:0]         zero_cnt;

   always_comb begin
      zero_cnt = '0;
      for (int i = 0; i < AREA; i++) begin
         zeros[i] = mask_in[i] & ~vals_in[i*PIX_W+BIT];
         ones[i]  = mask_in[i] &  vals_in[i*PIX_W+BIT];
         zero_cnt = zero_cnt + KW'(zeros[i]);
      end
   end

   always_comb begin
      acc_nx = acc_in;
      if (rank_in < zero_cnt) begin
         acc_nx[BIT] = 1'b0;
         mask_in_nx  = zeros;
         rank_nx     = rank_in;
      end else begin
         acc_nx[BIT] = 1'b1;
         mask_in_nx  = ones;
         rank_nx     = rank_in - zero_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else if (en) begin
         meta_ff.valid <= meta_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vals_ff           <= vals_in;
         mask_ff           <= mask_in_nx;
         rank_ff           <= rank_nx;
         acc_ff            <= acc_nx;
         meta_ff.frame_end <= meta_in.frame_end;
         meta_ff.interior  <= meta_in.interior;
         meta_ff.gray      <= meta_in.gray;
      end
   end

   assign vals_out = vals_ff;
   assign mask_out = mask_ff;
   assign rank_out = rank_ff;
   assign acc_out  = acc_ff;
   assign meta_out = meta_ff;

endmodule
`default_nettype wire

// ----- rtl/mfg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfg_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic csr_valid,
   input wire logic csr_ready
);

   // a held word is the only reason to stall the input
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a held result");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

   // a free output side never holds up the input
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !rsp_valid) |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

bind median_filter_7x7_gray_core mfg_checker u_mfg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
`default_nettype wire
